// ----- design/rea_pkg.sv -----
// ----------------------------------------------------------------------------
// rea_pkg
// Shared types and constants for the reprojection error accumulator.
// ----------------------------------------------------------------------------
package rea_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int CAM_REGS       = 6;
    localparam int QUOT_BITS      = 33;
    localparam int NUM_BITS       = 64;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_DEGEN = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_CHECK,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SQ_MUL,
        ST_SQ_ADD,
        ST_UPDATE,
        ST_FINISH,
        ST_MEAN_START,
        ST_MEAN_WAIT,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic done;
        logic sat;
    } div_rsp_t;

endpackage

// ----- design/reprojection_error_accumulator.sv -----
// ----------------------------------------------------------------------------
// reprojection_error_accumulator
// Projects each 3D point through the camera matrix, accumulates the squared
// reprojection error, and on the last beat emits the saturated mean.
// ----------------------------------------------------------------------------
// A counted point, after its beat, runs through the projection on the shared
// multiplier, a check, four divisions on the shared divider (each cut short when
// the quotient overflows), the squared error and the update; a skipped point ends
// after the check. The last beat then forms the mean on the divider and outputs
// it, or outputs at once with no counted point, waiting out any output stall. The
// next beat is taken in idle. Reset clears camera regs, sum, count and out_valid.
// ----------------------------------------------------------------------------
module reprojection_error_accumulator #(
    parameter int FRAC_BITS  = rea_pkg::FRAC_BITS_DEF,
    parameter int COUNT_BITS = rea_pkg::COUNT_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] meas_x,
    input  logic signed [31:0] meas_y,
    input  logic signed [31:0] meas_w,
    input  logic               meas_valid,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic signed [31:0] point_w,
    input  logic               last_point,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        mean_error_sq,
    output logic [15:0]        points_used,
    output logic [1:0]         status
);
    import rea_pkg::*;

    localparam int DW = NUM_BITS + FRAC_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    state_t state_reg, state_next;

    logic [63:0]               cam_reg [CAM_REGS];
    logic signed [31:0]        in_reg [8];
    logic                      mv_reg, last_reg;
    logic [3:0]                k_reg, k_next;
    logic [1:0]                idx_reg, idx_next;
    logic signed [63:0]        proj_reg [3];
    logic signed [63:0]        proj_next [3];
    logic signed [31:0]        qm_reg [2];
    logic signed [31:0]        qp_reg [2];
    logic signed [31:0]        qm_next [2];
    logic signed [31:0]        qp_next [2];
    logic signed [32:0]        mul_a, mul_b;
    logic signed [65:0]        mul_reg;
    logic [64:0]               add_reg, add_next;
    logic [63:0]               sum_reg, sum_next;
    logic [COUNT_BITS-1:0]     cnt_reg, cnt_next;
    logic                      degen_reg, degen_next;
    logic [31:0]               res_mean_reg, res_mean_next;
    logic [1:0]                res_status_reg, res_status_next;
    logic                      out_valid_reg, out_valid_next;
    logic [31:0]               out_mean_reg, out_mean_next;
    logic [15:0]               out_count_reg, out_count_next;
    logic [1:0]                out_status_reg, out_status_next;

    logic                      div_start;
    logic [DW-1:0]             div_dividend;
    logic [NUM_BITS-1:0]       div_divisor;
    div_rsp_t                  div_rsp;
    logic [QUOT_BITS-1:0]      div_q;

    logic signed [63:0]        num_s, den_s;
    logic [63:0]               num_mag, den_mag;
    logic                      neg;
    logic [QUOT_BITS-1:0]      lim, qmag;
    logic [31:0]               qval;
    logic [63:0]               cam_word;
    logic signed [31:0]        cam_entry;
    logic signed [65:0]        mul_sh;
    logic signed [32:0]        diff;
    logic [31:0]               diff_mag;
    logic [65:0]               sum_wide;
    logic [23:0]               cnt_ext;
    logic                      accept;

    rea_divider #(
        .DW(DW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .rsp      (div_rsp),
        .quotient (div_q)
    );

    assign accept = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (in_valid) state_next = ST_MUL;
            ST_MUL:        state_next = ST_ACC;
            ST_ACC:        state_next = (k_reg == 4'd11) ? ST_CHECK : ST_MUL;
            ST_CHECK:
            begin
                if (!mv_reg || proj_reg[2] == 64'sd0 || in_reg[2] == 32'sd0
                    || cnt_reg == COUNT_MAX)
                    state_next = ST_FINISH;
                else
                    state_next = ST_DIV_START;
            end
            ST_DIV_START:  state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                    state_next = (idx_reg == 2'd3) ? ST_SQ_MUL : ST_DIV_START;
            end
            ST_SQ_MUL:     state_next = ST_SQ_ADD;
            ST_SQ_ADD:     state_next = (idx_reg == 2'd1) ? ST_UPDATE : ST_SQ_MUL;
            ST_UPDATE:     state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!last_reg)
                    state_next = ST_IDLE;
                else if (cnt_reg == '0)
                    state_next = ST_OUTPUT;
                else
                    state_next = ST_MEAN_START;
            end
            ST_MEAN_START: state_next = ST_MEAN_WAIT;
            ST_MEAN_WAIT:  if (div_rsp.done) state_next = ST_OUTPUT;
            ST_OUTPUT:     if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cam_word  = cam_reg[{k_reg[3:2], k_reg[1]}];
        cam_entry = k_reg[0] ? signed'(cam_word[63:32]) : signed'(cam_word[31:0]);
        mul_sh    = mul_reg >>> FRAC_BITS;
        diff      = {qm_reg[idx_reg[0]][31], qm_reg[idx_reg[0]]}
                  - {qp_reg[idx_reg[0]][31], qp_reg[idx_reg[0]]};
        diff_mag  = diff[32] ? 32'(-diff) : diff[31:0];
        sum_wide  = {2'b00, sum_reg} + {1'b0, add_reg};
        cnt_ext   = 24'(cnt_reg);

        unique case (idx_reg)
            2'd0:    begin num_s = 64'(in_reg[0]); den_s = 64'(in_reg[2]); end
            2'd1:    begin num_s = proj_reg[0];    den_s = proj_reg[2];    end
            2'd2:    begin num_s = 64'(in_reg[1]); den_s = 64'(in_reg[2]); end
            default: begin num_s = proj_reg[1];    den_s = proj_reg[2];    end
        endcase
        num_mag = num_s[63] ? 64'(-num_s) : 64'(num_s);
        den_mag = den_s[63] ? 64'(-den_s) : 64'(den_s);
        neg     = num_s[63] ^ den_s[63];
        lim     = neg ? 33'h080000000 : 33'h07FFFFFFF;
        qmag    = (div_rsp.sat || div_q > lim) ? lim : div_q;
        qval    = neg ? 32'(-qmag) : qmag[31:0];

        if (state_reg == ST_MEAN_START || state_reg == ST_MEAN_WAIT)
        begin
            div_dividend = DW'(sum_reg);
            div_divisor  = 64'(cnt_reg);
        end
        else
        begin
            div_dividend = DW'(num_mag) << FRAC_BITS;
            div_divisor  = den_mag;
        end
        div_start = (state_reg == ST_DIV_START) || (state_reg == ST_MEAN_START);

        if (state_reg == ST_SQ_MUL)
        begin
            mul_a = {1'b0, diff_mag};
            mul_b = {1'b0, diff_mag};
        end
        else
        begin
            mul_a = 33'(cam_entry);
            mul_b = 33'(in_reg[4 + 32'(k_reg[1:0])]);
        end
    end

    always_comb
    begin
        k_next          = k_reg;
        idx_next        = idx_reg;
        proj_next       = proj_reg;
        qm_next         = qm_reg;
        qp_next         = qp_reg;
        add_next        = add_reg;
        sum_next        = sum_reg;
        cnt_next        = cnt_reg;
        degen_next      = degen_reg;
        res_mean_next   = res_mean_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_mean_next   = out_mean_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        in_stall        = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                k_next    = '0;
                proj_next = '{default: 64'sd0};
            end
            ST_ACC:
            begin
                proj_next[k_reg[3:2]] = proj_reg[k_reg[3:2]] + mul_sh[63:0];
                k_next = k_reg + 1'b1;
            end
            ST_CHECK:
            begin
                idx_next = '0;
                add_next = '0;
                if (mv_reg && (proj_reg[2] == 64'sd0 || in_reg[2] == 32'sd0))
                    degen_next = 1'b1;
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (idx_reg[0])
                        qp_next[idx_reg[1]] = qval;
                    else
                        qm_next[idx_reg[1]] = qval;
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SQ_ADD:
            begin
                add_next = add_reg + 65'(mul_reg[63:0] >> FRAC_BITS);
                idx_next = idx_reg + 1'b1;
            end
            ST_UPDATE:
            begin
                sum_next = (sum_wide[65:64] != 2'b00) ? {64{1'b1}} : sum_wide[63:0];
                cnt_next = cnt_reg + 1'b1;
            end
            ST_FINISH:
            begin
                res_mean_next   = '0;
                res_status_next = STATUS_EMPTY;
            end
            ST_MEAN_WAIT:
            begin
                if (div_rsp.done)
                begin
                    res_mean_next = (div_rsp.sat || div_q[32]) ? 32'hFFFFFFFF : div_q[31:0];
                    res_status_next = degen_reg ? STATUS_DEGEN : STATUS_OK;
                end
            end
            ST_OUTPUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_mean_next   = res_mean_reg;
                    out_count_next  = (cnt_ext > 24'h00FFFF) ? 16'hFFFF : cnt_ext[15:0];
                    out_status_next = res_status_reg;
                    sum_next        = '0;
                    cnt_next        = '0;
                    degen_next      = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cam_reg        <= '{default: 64'd0};
            sum_reg        <= '0;
            cnt_reg        <= '0;
            degen_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            k_reg          <= '0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            degen_reg     <= degen_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            idx_reg       <= idx_next;
            if (cfg_we && (32'(cfg_index) < CAM_REGS))
                cam_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg        <= mul_a * mul_b;
        proj_reg       <= proj_next;
        qm_reg         <= qm_next;
        qp_reg         <= qp_next;
        add_reg        <= add_next;
        res_mean_reg   <= res_mean_next;
        res_status_reg <= res_status_next;
        out_mean_reg   <= out_mean_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
        if (accept)
        begin
            in_reg[0] <= meas_x;
            in_reg[1] <= meas_y;
            in_reg[2] <= meas_w;
            in_reg[3] <= 32'sd0;
            in_reg[4] <= point_x;
            in_reg[5] <= point_y;
            in_reg[6] <= point_z;
            in_reg[7] <= point_w;
            mv_reg    <= meas_valid;
            last_reg  <= last_point;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mean_error_sq = out_mean_reg;
    assign points_used   = out_count_reg;
    assign status        = out_status_reg;

endmodule

// ----- design/rea_divider.sv -----
// ----------------------------------------------------------------------------
// rea_divider
// Restoring divider, one quotient bit per cycle, with overflow detection.
// ----------------------------------------------------------------------------
module rea_divider #(
    parameter int DW = 80
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [DW-1:0]                  dividend,
    input  logic [rea_pkg::NUM_BITS-1:0]   divisor,
    output rea_pkg::div_rsp_t              rsp,
    output logic [rea_pkg::QUOT_BITS-1:0]  quotient
);
    import rea_pkg::*;

    localparam int CW = $clog2(QUOT_BITS);

    logic                 busy_reg, busy_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [NUM_BITS-1:0]  rem_reg, rem_next;
    logic [NUM_BITS-1:0]  den_reg, den_next;
    logic [QUOT_BITS-1:0] work_reg, work_next;
    logic [QUOT_BITS-1:0] q_reg, q_next;
    logic                 done_reg, done_next;
    logic                 sat_reg, sat_next;
    logic [DW-1:0]        hi;
    logic [NUM_BITS:0]    trial;
    logic [NUM_BITS:0]    diff;
    logic                 ge;

    always_comb
    begin
        hi        = dividend >> QUOT_BITS;
        trial     = {rem_reg, work_reg[QUOT_BITS-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        work_next = work_reg;
        q_next    = q_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        if (start)
        begin
            den_next  = divisor;
            work_next = dividend[QUOT_BITS-1:0];
            rem_next  = hi[NUM_BITS-1:0];
            cnt_next  = '0;
            q_next    = '0;
            if (hi >= DW'(divisor))
            begin
                sat_next  = 1'b1;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                sat_next  = 1'b0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[NUM_BITS-1:0] : trial[NUM_BITS-1:0];
            q_next    = {q_reg[QUOT_BITS-2:0], ge};
            work_next = {work_reg[QUOT_BITS-2:0], 1'b0};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CW'(QUOT_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            sat_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            sat_reg  <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        work_reg <= work_next;
        q_reg    <= q_next;
    end

    assign rsp.done = done_reg;
    assign rsp.sat  = sat_reg;
    assign quotient = q_reg;

endmodule

// ----- sim/reprojection_error_accumulator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reprojection_error_accumulator_test
// Drives point correspondences through the accumulator under several camera
// matrices, predicts each mean squared error in a scoreboard and compares
// every result beat field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module reprojection_error_accumulator_test;

    import rea_pkg::*;

    localparam int  LIMIT_CYCLES = 2_500_000;
    localparam int  SETTLE       = 300;
    localparam int  REG_IDX_MAX  = 5;
    localparam logic [31:0] ONE  = 32'h0001_0000;

    typedef struct {
        logic [31:0] mx, my, mw;
        logic        mv;
        logic [31:0] px, py, pz, pw;
        logic        last;
    } corr_t;

    typedef struct {
        logic [31:0] mean;
        logic [15:0] used;
        logic [1:0]  st;
    } mean_t;

    class error_scoreboard;
        logic [63:0]    cam[6];
        logic [63:0]    err_sum;
        int unsigned    count;
        bit             degen;
        mean_t          pending[$];
        int             errors;

        function new();
            foreach (cam[i]) cam[i] = '0;
            err_sum = '0;
            count   = 0;
            degen   = 0;
            errors  = 0;
        endfunction

        function void write_reg(int idx, logic [63:0] val);
            if (idx <= REG_IDX_MAX) cam[idx] = val;
        endfunction

        function longint signed entry(int r, int c);
            logic [63:0] rv;
            rv = cam[r * 2 + c / 2];
            return (c % 2) ? longint'($signed(rv[63:32])) : longint'($signed(rv[31:0]));
        endfunction

        function longint signed divide(longint signed num, longint signed den);
            logic [63:0] un, ud, q, rem, lim;
            bit          neg;
            un  = num < 0 ? -num : num;
            ud  = den < 0 ? -den : den;
            neg = (num < 0) != (den < 0);
            q   = un / ud;
            rem = un % ud;
            lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            if (q > (64'd1 << 15))
                q = lim;
            else
            begin
                for (int i = 0; i < 16; i++)
                begin
                    rem = rem << 1;
                    q   = q << 1;
                    if (rem >= ud)
                    begin
                        rem = rem - ud;
                        q[0] = 1'b1;
                    end
                end
                if (q > lim) q = lim;
            end
            return neg ? -longint'(q) : longint'(q);
        endfunction

        function logic [63:0] sq_err(longint signed a, longint signed b);
            logic [63:0] d;
            d = (a - b < 0) ? b - a : a - b;
            if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
            return (d * d) >> 16;
        endfunction

        function void note_item(corr_t it);
            longint signed pt[4], proj[3];
            longint signed mx, my, mw;
            logic [63:0]   e;
            logic [64:0]   s;
            mean_t         m;
            mx = $signed(it.mx);
            my = $signed(it.my);
            mw = $signed(it.mw);
            pt[0] = $signed(it.px);
            pt[1] = $signed(it.py);
            pt[2] = $signed(it.pz);
            pt[3] = $signed(it.pw);
            if (it.mv)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    proj[r] = 0;
                    for (int c = 0; c < 4; c++)
                        proj[r] += (entry(r, c) * pt[c]) >>> 16;
                end
                if (proj[2] == 0 || mw == 0)
                    degen = 1;
                else if (count < 65535)
                begin
                    e = sq_err(divide(mx, mw), divide(proj[0], proj[2]))
                      + sq_err(divide(my, mw), divide(proj[1], proj[2]));
                    s = {1'b0, err_sum} + {1'b0, e};
                    err_sum = s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
                    count++;
                end
            end
            if (!it.last) return;
            if (count == 0)
            begin
                m.mean = '0;
                m.used = '0;
                m.st   = STATUS_EMPTY;
            end
            else
            begin
                e      = err_sum / count;
                m.mean = e > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : e[31:0];
                m.used = count[15:0];
                m.st   = degen ? STATUS_DEGEN : STATUS_OK;
            end
            pending.push_back(m);
            err_sum = '0;
            count   = 0;
            degen   = 0;
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(logic [31:0] mean, logic [15:0] used, logic [1:0] st);
            mean_t m;
            if (pending.size() == 0)
            begin
                report("unexpected result beat", mean, 0);
                return;
            end
            m = pending.pop_front();
            if (mean !== m.mean) report("mean_error_sq", mean, m.mean);
            if (used !== m.used) report("points_used", used, m.used);
            if (st !== m.st) report("status", st, m.st);
        endtask
    endclass

    logic        clk, rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid, in_stall;
    logic [31:0] meas_x, meas_y, meas_w, point_x, point_y, point_z, point_w;
    logic        meas_valid, last_point;
    logic        out_valid, out_stall;
    logic [31:0] mean_error_sq;
    logic [15:0] points_used;
    logic [1:0]  status;

    error_scoreboard sb;
    int  cycles;
    bit  calm;
    bit  hold_req;

    reprojection_error_accumulator dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .meas_x(meas_x), .meas_y(meas_y), .meas_w(meas_w), .meas_valid(meas_valid),
        .point_x(point_x), .point_y(point_y), .point_z(point_z), .point_w(point_w),
        .last_point(last_point),
        .out_valid(out_valid), .out_stall(out_stall),
        .mean_error_sq(mean_error_sq), .points_used(points_used), .status(status)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("** reprojection_error_accumulator: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_item('{meas_x, meas_y, meas_w, meas_valid,
                           point_x, point_y, point_z, point_w, last_point});
        if (rst_n && out_valid && !out_stall)
            sb.check_result(mean_error_sq, points_used, status);
    end

    initial
    begin
        out_stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1;
                repeat (3000) @(negedge clk);
                hold_req = 0;
                out_stall = 0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_stall = 1;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                out_stall = 0;
            end
        end
    end

    task write_reg(int idx, logic [63:0] val);
        @(negedge clk);
        cfg_we    = 1;
        cfg_index = 3'(idx);
        cfg_data  = val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we = 0;
    endtask

    task send(corr_t it);
        @(negedge clk);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid = 0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        {meas_x, meas_y, meas_w, meas_valid} = {it.mx, it.my, it.mw, it.mv};
        {point_x, point_y, point_z, point_w} = {it.px, it.py, it.pz, it.pw};
        last_point = it.last;
        in_valid   = 1;
        do @(posedge clk); while (in_stall);
    endtask

    task drain();
        @(negedge clk);
        in_valid = 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function logic [31:0] near(int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    function corr_t random_item(logic last);
        corr_t it;
        int    k;
        k = $urandom_range(0, 15);
        if (k < 2)
            it = '{$urandom, $urandom, $urandom, 1'b1, $urandom, $urandom, $urandom,
                   $urandom, last};
        else
        begin
            it.mx = near(100 << 16);
            it.my = near(100 << 16);
            it.mw = (k == 2) ? near(4 << 16) : ONE;
            it.mv = (k != 3);
            it.px = near(60 << 16);
            it.py = near(60 << 16);
            it.pz = (k == 4) ? 32'd0 : near(20 << 16);
            it.pw = (k == 5) ? near(2 << 16) : ONE;
            it.last = last;
            if (k == 6) it.mw = 0;
        end
        return it;
    endfunction

    task load_camera(int mode);
        logic [63:0] v[6];
        for (int i = 0; i < 6; i++)
        begin
            case (mode)
                0: v[i] = 64'd0;
                1: v[i] = {$urandom, $urandom};
                2: v[i] = 64'hFFFF_FFFF_FFFF_FFFF;
                3: v[i] = 64'h8000_0000_8000_0000;
                4: v[i] = 64'h7FFF_FFFF_7FFF_FFFF;
                default: v[i] = {near(2 << 16), near(2 << 16)};
            endcase
        end
        if (mode >= 5)
        begin
            v[0] = {32'd0, 32'h0002_0000};
            v[2] = {32'h0002_0000, 32'd0};
            v[4] = {32'd0, 32'd0};
            v[5] = {32'd0, ONE};
        end
        for (int i = 0; i < 6; i++) write_reg(i, v[i]);
        write_reg(REG_IDX_MAX + 1 + $urandom_range(0, 1), {$urandom, $urandom});
    endtask

    initial
    begin
        corr_t it;
        int    modes[7] = '{5, 1, 2, 3, 4, 0, 6};
        sb = new();
        cycles = 0; calm = 0; hold_req = 0;
        rst_n = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0; in_valid = 0;
        {meas_x, meas_y, meas_w, meas_valid, last_point} = '0;
        {point_x, point_y, point_z, point_w} = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        load_camera(5);
        send('{ONE, ONE, ONE, 1'b1, ONE, ONE, ONE, ONE, 1'b0});
        send('{32'h7FFF_FFFF, 32'h8000_0000, ONE, 1'b1, ONE, ONE, ONE, ONE, 1'b0});
        send('{ONE, ONE, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, ONE,
               ONE, 1'b0});
        send('{ONE, ONE, ONE, 1'b0, ONE, ONE, ONE, ONE, 1'b0});
        send('{ONE, ONE, 32'd0, 1'b1, ONE, ONE, ONE, ONE, 1'b0});
        send('{ONE, ONE, ONE, 1'b1, ONE, ONE, 32'd0, ONE, 1'b0});
        send('{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1});
        send('{ONE, ONE, ONE, 1'b0, ONE, ONE, ONE, ONE, 1'b1});
        send('{ONE, ONE, 32'd0, 1'b1, ONE, ONE, ONE, ONE, 1'b1});
        send('{ONE, 32'h0003_0000, ONE, 1'b1, 32'hFFFF_0000, ONE, ONE, ONE, 1'b1});
        send('{32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF,
               32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1});
        drain();

        for (int p = 0; p < 7; p++)
        begin
            load_camera(modes[p]);
            if (p == 1) hold_req = 1;
            if (p == 6) calm = 1;
            for (int n = 0; n < 275; n++)
            begin
                it = random_item(n == 274 || $urandom_range(0, 7) == 0);
                send(it);
            end
            drain();
        end

        if (sb.errors == 0)
            $display("** reprojection_error_accumulator: PASSED **");
        else
            $display("** reprojection_error_accumulator: FAILED **");
        $finish;
    end

endmodule
